### rtl/core/mlps_pkg.sv
// Shared types and codes for the multilevel priority scheduler.
// No dependencies.
package mlps_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_SCHEDULE = 2'd1,
    ACT_TAKE     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  prio;
    logic [15:0] ptime;
  } proc_t;

endpackage

### rtl/core/multilevel_priority_scheduler_top.sv
// Multilevel priority scheduler: sorted pending store and ready FIFO in
// two RAMs with registered reads. Depends on mlps_pkg. Errors and unused
// actions are answered from idle; take reads the ready FIFO head;
// schedule moves the pending head to the ready FIFO and shifts the rest
// up; insert shifts entries down one at a time through the pending RAM's
// single read and write port. busy is high while an item is at work; one
// item at a time. The result is a one-cycle out_valid beat. Synchronous
// active-low reset clears the state, counts and pointers; RAM contents stay.
module multilevel_priority_scheduler_top #(
  parameter int LEVELS        = 8,
  parameter int PENDING_DEPTH = 64,
  parameter int READY_DEPTH   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_proc_id,
  input  logic [3:0]  in_proc_priority,
  input  logic [15:0] in_proc_time,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_id,
  output logic [3:0]  out_priority,
  output logic [15:0] out_time
);
  import mlps_pkg::*;

  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int RW = $clog2(READY_DEPTH);
  localparam logic [PW:0] PDEPTH = PW'(0) + (PW+1)'(PENDING_DEPTH);
  localparam logic [RW:0] RDEPTH = (RW+1)'(READY_DEPTH);
  localparam logic [4:0]  LEV    = 5'(LEVELS);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_INS_FIN, S_SCH0, S_SCH, S_TAKE
  } state_t;

  state_t      state_r;
  logic [PW:0] pcount_r;
  logic [RW:0] rcount_r;
  logic [RW-1:0] rhead_r, rtail_r;
  logic [PW:0] idx_r;
  proc_t       new_r;

  proc_t pmem [PENDING_DEPTH];
  proc_t rmem [READY_DEPTH];
  proc_t prdata, rrdata;

  logic          p_we, r_we, p_re, r_re;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [RW-1:0] r_raddr;
  proc_t         p_wdata;

  proc_t in_e;
  logic  stays;
  logic [PW:0] idx_m1, idx_m2, idx_p1;

  assign in_e   = '{id: in_proc_id, prio: in_proc_priority, ptime: in_proc_time};
  assign stays  = (prdata.prio > new_r.prio) ||
                  (prdata.prio == new_r.prio && prdata.ptime < new_r.ptime);
  assign idx_m1 = idx_r - (PW+1)'(1);
  assign idx_m2 = idx_r - (PW+1)'(2);
  assign idx_p1 = idx_r + (PW+1)'(1);
  assign busy   = (state_r != S_IDLE);

  function automatic logic [RW-1:0] rnext(input logic [RW-1:0] p);
    return (p == RW'(READY_DEPTH - 1)) ? '0 : p + RW'(1);
  endfunction

  always_comb begin
    p_we    = 1'b0;
    p_waddr = idx_r[PW-1:0];
    p_wdata = prdata;
    p_re    = 1'b0;
    p_raddr = '0;
    r_we    = 1'b0;
    r_re    = 1'b0;
    r_raddr = rhead_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_action == ACT_INSERT && in_proc_priority != 4'd0 &&
            {1'b0, in_proc_priority} <= LEV && pcount_r < PDEPTH) begin
          if (pcount_r == '0) begin
            p_we    = 1'b1;
            p_waddr = '0;
            p_wdata = in_e;
          end else begin
            p_re    = 1'b1;
            p_raddr = PW'(pcount_r - (PW+1)'(1));
          end
        end
        if (start && in_action == ACT_SCHEDULE && pcount_r != '0 && rcount_r < RDEPTH)
          p_re = 1'b1;
        if (start && in_action == ACT_TAKE && rcount_r != '0)
          r_re = 1'b1;
      end
      S_INS: begin
        p_we = 1'b1;
        if (stays) begin
          p_wdata = new_r;
        end else if (idx_r != (PW+1)'(1)) begin
          p_re    = 1'b1;
          p_raddr = idx_m2[PW-1:0];
        end
      end
      S_INS_FIN: begin
        p_we    = 1'b1;
        p_waddr = '0;
        p_wdata = new_r;
      end
      S_SCH0: begin
        r_we = 1'b1;
        if (pcount_r != (PW+1)'(1)) begin
          p_re    = 1'b1;
          p_raddr = PW'(1);
        end
      end
      S_SCH: begin
        p_we    = 1'b1;
        p_waddr = idx_m1[PW-1:0];
        if (idx_p1 != pcount_r) begin
          p_re    = 1'b1;
          p_raddr = idx_p1[PW-1:0];
        end
      end
      S_TAKE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    if (p_re) prdata <= pmem[p_raddr];
    if (r_we) rmem[rtail_r] <= prdata;
    if (r_re) rrdata <= rmem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pcount_r  <= '0;
      rcount_r  <= '0;
      rhead_r   <= '0;
      rtail_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            new_r        <= in_e;
            idx_r        <= pcount_r;
            out_status   <= ST_NONE;
            out_id       <= '0;
            out_priority <= '0;
            out_time     <= '0;
            unique case (action_t'(in_action))
              ACT_INSERT: begin
                if (in_proc_priority == 4'd0 || {1'b0, in_proc_priority} > LEV) begin
                  out_status <= ST_RANGE;
                  out_valid  <= 1'b1;
                end else if (pcount_r >= PDEPTH) begin
                  out_status <= ST_FULL;
                  out_valid  <= 1'b1;
                end else if (pcount_r == '0) begin
                  out_status <= ST_OK;
                  out_valid  <= 1'b1;
                  pcount_r   <= (PW+1)'(1);
                end else begin
                  state_r <= S_INS;
                end
              end
              ACT_SCHEDULE: begin
                if (pcount_r == '0) begin
                  out_valid <= 1'b1;
                end else if (rcount_r >= RDEPTH) begin
                  out_status <= ST_FULL;
                  out_valid  <= 1'b1;
                end else begin
                  state_r <= S_SCH0;
                end
              end
              ACT_TAKE: begin
                if (rcount_r == '0) out_valid <= 1'b1;
                else state_r <= S_TAKE;
              end
              ACT_NONE: out_valid <= 1'b1;
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_INS: begin
          if (stays) begin
            pcount_r   <= pcount_r + (PW+1)'(1);
            out_status <= ST_OK;
            out_valid  <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            idx_r <= idx_m1;
            if (idx_r == (PW+1)'(1)) state_r <= S_INS_FIN;
          end
        end
        S_INS_FIN: begin
          pcount_r   <= pcount_r + (PW+1)'(1);
          out_status <= ST_OK;
          out_valid  <= 1'b1;
          state_r    <= S_IDLE;
        end
        S_SCH0: begin
          new_r    <= prdata;
          rtail_r  <= rnext(rtail_r);
          rcount_r <= rcount_r + (RW+1)'(1);
          idx_r    <= (PW+1)'(1);
          if (pcount_r == (PW+1)'(1)) begin
            pcount_r     <= '0;
            out_status   <= ST_OK;
            out_id       <= prdata.id;
            out_priority <= prdata.prio;
            out_time     <= prdata.ptime;
            out_valid    <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_SCH;
          end
        end
        S_SCH: begin
          idx_r <= idx_p1;
          if (idx_p1 == pcount_r) begin
            pcount_r     <= pcount_r - (PW+1)'(1);
            out_status   <= ST_OK;
            out_id       <= new_r.id;
            out_priority <= new_r.prio;
            out_time     <= new_r.ptime;
            out_valid    <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_TAKE: begin
          rhead_r      <= rnext(rhead_r);
          rcount_r     <= rcount_r - (RW+1)'(1);
          out_status   <= ST_OK;
          out_id       <= rrdata.id;
          out_priority <= rrdata.prio;
          out_time     <= rrdata.ptime;
          out_valid    <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");
  a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PDEPTH) else $error("pending count overflow");
  a_rcount: assert property (@(posedge clk) disable iff (!rst_n)
    rcount_r <= RDEPTH) else $error("ready count overflow");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_id == '0 && out_priority == '0 &&
    out_time == '0)) else $error("error beat carries a process");
  a_take_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE) |=> (rcount_r == $past(rcount_r) - (RW+1)'(1)))
    else $error("take did not pop");
`endif

endmodule
